// File: design/fcts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcts_pkg
// Shared constants, codes and the pipeline context for the floor texel shader.
// ----------------------------------------------------------------------------
package fcts_pkg;

    // texture geometry
    localparam int TEX_SIZE    = 64;
    localparam int TEX_BITS    = $clog2(TEX_SIZE);
    localparam int TEX_COUNT   = 2;
    localparam int TEX_AREA    = TEX_SIZE * TEX_SIZE;
    localparam int STORE_DEPTH = TEX_COUNT * TEX_AREA;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // q8.16 word width and divider depth (one quotient bit per stage)
    localparam int Q_W        = 24;
    localparam int DIV_STAGES = Q_W;
    localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SCREEN_HEIGHT  = 2'd0,
        REG_PLAYER_X       = 2'd1,
        REG_PLAYER_Y       = 2'd2,
        REG_TEXTURE_CHOICE = 2'd3
    } t_reg_index;

    // result status codes
    typedef enum logic [1:0] {
        ST_SHADED     = 2'd0,
        ST_NO_TEXTURE = 2'd1,
        ST_HORIZON    = 2'd2
    } t_status;

    // item context carried down the pipeline
    typedef struct packed {
        logic                mode;
        logic [11:0]         column;
        logic [9:0]          row;
        t_status             status;
        logic                side;
        logic                ray_x_positive;
        logic                ray_y_positive;
        logic [7:0]          map_x;
        logic [7:0]          map_y;
        logic [15:0]         wall_fraction;
        logic [Q_W-1:0]      wall_distance;
        logic [12:0]         load_address;
        logic [31:0]         load_word;
        logic [1:0]          tex_sel;
        logic                sat;
        logic [Q_W-1:0]      row_dist;
        logic [Q_W-1:0]      weight;
        logic [31:0]         px_wall;
        logic [31:0]         px_pos;
        logic [31:0]         py_wall;
        logic [31:0]         py_pos;
        logic [STORE_AW-1:0] taddr;
        logic [31:0]         texel;
    } t_ctx;

endpackage
`default_nettype wire

// File: design/fcts_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcts_div
// Pipelined restoring divider, one quotient bit per stage, 24 stages.
// The starting remainder must be below the divisor for a valid quotient.
// ----------------------------------------------------------------------------
module fcts_div
    import fcts_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [Q_W-1:0] i_rem,
    input  wire logic [Q_W-1:0] i_low,
    input  wire logic [Q_W-1:0] i_den,
    output logic      [Q_W-1:0] o_quo
);

    logic [Q_W-1:0] r_rem [DIV_STAGES];
    logic [Q_W-1:0] r_low [DIV_STAGES];
    logic [Q_W-1:0] r_den [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [Q_W-1:0] rem_in;
        logic [Q_W-1:0] low_in;
        logic [Q_W-1:0] den_in;
        logic [Q_W:0]   trial;
        logic           ge;

        // stage inputs
        if (k == 0) begin : g_first
            assign rem_in = i_rem;
            assign low_in = i_low;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign den_in = r_den[k-1];
        end

        // shift in next dividend bit, compare and subtract
        assign trial = {rem_in, low_in[Q_W-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? Q_W'(trial - {1'b0, den_in}) : trial[Q_W-1:0];
                r_low[k] <= {low_in[Q_W-2:0], ge};
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_low[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: design/floor_cast_texel_shader_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// floor_cast_texel_shader_unit
// Floor casting texel shader: row distance, weight, floor point, texel
// fetch and per-channel shading, in Q8.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one beat per item. Mode 0 beats write
//   a texel word into the texture store and give no result. Mode 1 beats
//   shade one floor pixel and give exactly one result beat.
//   Output channel (o_valid / i_stall): one beat per shaded pixel.
//   Configuration channel (i_cfg_valid / o_cfg_ready): always ready; write
//   only while the pipeline is empty.
//   One item is taken every cycle unless o_stall is high. The pipeline depth
//   is set by the three 24-stage bit-serial dividers (row distance, weight,
//   colour shading) plus seven context stages.
//   Reset clears all valid bits and loads the register defaults; the texture
//   store keeps whatever it held and must be written before it is read.
//   A stall on the output with a result waiting freezes the whole pipeline
//   and raises o_stall in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module floor_cast_texel_shader_unit
    import fcts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    // input items
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [11:0] i_column,
    input  wire logic [9:0]  i_row,
    input  wire logic        i_side,
    input  wire logic        i_ray_x_positive,
    input  wire logic        i_ray_y_positive,
    input  wire logic [7:0]  i_map_x,
    input  wire logic [7:0]  i_map_y,
    input  wire logic [15:0] i_wall_fraction,
    input  wire logic [23:0] i_wall_distance,
    input  wire logic [12:0] i_load_address,
    input  wire logic [31:0] i_load_word,
    // results
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_pixel_column,
    output logic [9:0]       o_pixel_row,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_green,
    output logic [7:0]       o_red,
    output logic [7:0]       o_alpha,
    output logic [1:0]       o_status
);

    // configuration registers
    logic [9:0]     r_height;
    logic [Q_W-1:0] r_player_x;
    logic [Q_W-1:0] r_player_y;
    logic [1:0]     r_tex_choice;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height     <= 10'd480;
            r_player_x   <= '0;
            r_player_y   <= '0;
            r_tex_choice <= 2'd1;
        end else if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_SCREEN_HEIGHT:  r_height     <= i_cfg_data[9:0];
                REG_PLAYER_X:       r_player_x   <= i_cfg_data;
                REG_PLAYER_Y:       r_player_y   <= i_cfg_data;
                REG_TEXTURE_CHOICE: r_tex_choice <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // global advance: freeze everything while a result waits on a stall
    logic r_vo;
    logic en;

    assign en      = !(r_vo && i_stall);
    assign o_stall = !en;

    // stage 0: capture beat, classify
    logic   r_v0;
    t_ctx   r_c0;
    t_ctx   n_c0;
    logic [10:0] twice_row;
    logic [1:0]  tsel;

    always_comb begin
        twice_row = {i_row, 1'b0};
        tsel      = r_tex_choice - 2'd1;
        n_c0                = r_c0;
        n_c0.mode           = i_mode;
        n_c0.column         = i_column;
        n_c0.row            = i_row;
        n_c0.side           = i_side;
        n_c0.ray_x_positive = i_ray_x_positive;
        n_c0.ray_y_positive = i_ray_y_positive;
        n_c0.map_x          = i_map_x;
        n_c0.map_y          = i_map_y;
        n_c0.wall_fraction  = i_wall_fraction;
        n_c0.wall_distance  = i_wall_distance;
        n_c0.load_address   = i_load_address;
        n_c0.load_word      = i_load_word;
        n_c0.tex_sel        = tsel;
        n_c0.sat            = 1'b0;
        if (twice_row <= {1'b0, r_height}) begin
            n_c0.status = ST_HORIZON;
        end else if (r_tex_choice == 2'd0 || 32'(tsel) >= 32'(TEX_COUNT)) begin
            n_c0.status = ST_NO_TEXTURE;
        end else begin
            n_c0.status = ST_SHADED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0 <= n_c0;
        end
    end

    // row distance divider: (H << 16) / (2*row - H)
    logic [10:0]    den1;
    logic [Q_W-1:0] quo1;
    t_ctx           c_in1;

    always_comb begin
        den1       = {r_c0.row, 1'b0} - {1'b0, r_height};
        c_in1      = r_c0;
        c_in1.sat  = ({9'd0, r_height[9:8]} >= den1);
    end

    fcts_div u_div_dist (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (Q_W'(r_height[9:8])),
        .i_low ({r_height[7:0], 16'd0}),
        .i_den (Q_W'(den1)),
        .o_quo (quo1)
    );

    logic r_vl1 [DIV_STAGES];
    t_ctx r_l1  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vl1[k] <= 1'b0;
            end
        end else if (en) begin
            r_vl1[0] <= r_v0;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_vl1[k] <= r_vl1[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1[0] <= c_in1;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_l1[k] <= r_l1[k-1];
            end
        end
    end

    // stage 1: saturate distance
    logic r_v1;
    t_ctx r_c1;
    t_ctx n_c1;

    always_comb begin
        n_c1          = r_l1[DIV_STAGES-1];
        n_c1.row_dist = n_c1.sat ? Q_MAX : quo1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_vl1[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= n_c1;
        end
    end

    // weight divider: (row_dist << 16) / wall_distance
    logic [Q_W-1:0] den2;
    logic [Q_W-1:0] quo2;
    t_ctx           c_in2;

    always_comb begin
        den2      = (r_c1.wall_distance == '0) ? Q_W'(1) : r_c1.wall_distance;
        c_in2     = r_c1;
        c_in2.sat = ({8'd0, r_c1.row_dist[23:8]} >= den2);
    end

    fcts_div u_div_weight (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem ({8'd0, r_c1.row_dist[23:8]}),
        .i_low ({r_c1.row_dist[7:0], 16'd0}),
        .i_den (den2),
        .o_quo (quo2)
    );

    logic r_vl2 [DIV_STAGES];
    t_ctx r_l2  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vl2[k] <= 1'b0;
            end
        end else if (en) begin
            r_vl2[0] <= r_v1;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_vl2[k] <= r_vl2[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l2[0] <= c_in2;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_l2[k] <= r_l2[k-1];
            end
        end
    end

    // stage 2: saturate weight
    logic r_v2;
    t_ctx r_c2;
    t_ctx n_c2;

    always_comb begin
        n_c2        = r_l2[DIV_STAGES-1];
        n_c2.weight = n_c2.sat ? Q_MAX : quo2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_vl2[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2 <= n_c2;
        end
    end

    // stage 3: wall point and products, kept modulo 2^32
    logic r_v3;
    t_ctx r_c3;
    t_ctx n_c3;
    logic [31:0] wall_x;
    logic [31:0] wall_y;
    logic [31:0] w32;
    logic [31:0] omw32;

    always_comb begin
        if (!r_c2.side) begin
            wall_x = {8'd0, r_c2.map_x, 16'd0}
                   + (r_c2.ray_x_positive ? 32'd0 : 32'(Q_ONE));
            wall_y = {8'd0, r_c2.map_y, r_c2.wall_fraction};
        end else begin
            wall_x = {8'd0, r_c2.map_x, r_c2.wall_fraction};
            wall_y = {8'd0, r_c2.map_y, 16'd0}
                   + (r_c2.ray_y_positive ? 32'd0 : 32'(Q_ONE));
        end
        w32   = {8'd0, r_c2.weight};
        omw32 = 32'(Q_ONE) - w32;
        n_c3         = r_c2;
        n_c3.px_wall = 32'(w32 * wall_x);
        n_c3.px_pos  = 32'(omw32 * {8'd0, r_player_x});
        n_c3.py_wall = 32'(w32 * wall_y);
        n_c3.py_pos  = 32'(omw32 * {8'd0, r_player_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3 <= n_c3;
        end
    end

    // stage 4: floor point sums and texel address
    logic r_v4;
    t_ctx r_c4;
    t_ctx n_c4;
    logic [31:0] sum_x;
    logic [31:0] sum_y;
    logic [TEX_BITS-1:0] tex_x;
    logic [TEX_BITS-1:0] tex_y;

    always_comb begin
        sum_x = r_c3.px_wall + r_c3.px_pos;
        sum_y = r_c3.py_wall + r_c3.py_pos;
        tex_x = sum_x[31 -: TEX_BITS];
        tex_y = sum_y[31 -: TEX_BITS];
        n_c4       = r_c3;
        n_c4.taddr = STORE_AW'(32'(r_c3.tex_sel) * 32'(TEX_AREA)
                             + 32'(tex_y) * 32'(TEX_SIZE) + 32'(tex_x));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c4 <= n_c4;
        end
    end

    // texture store: writes and reads both happen at stage 4, in item order
    logic [31:0] r_store [STORE_DEPTH];
    logic [31:0] r_texel;
    logic        store_we;

    assign store_we = en && r_v4 && !r_c4.mode
                   && (32'(r_c4.load_address) < 32'(STORE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_c4.load_address[STORE_AW-1:0]] <= r_c4.load_word;
        end
        if (en) begin
            r_texel <= r_store[r_c4.taddr];
        end
    end

    // stage 5: texel available
    logic r_v5;
    t_ctx r_c5;
    t_ctx c_in3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c5 <= r_c4;
        end
    end

    always_comb begin
        c_in3       = r_c5;
        c_in3.texel = r_texel;
    end

    // shading dividers: (channel << 16) / row_dist
    logic [Q_W-1:0] quo_b;
    logic [Q_W-1:0] quo_g;
    logic [Q_W-1:0] quo_r;

    fcts_div u_div_blue (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem ('0),
        .i_low ({r_texel[7:0], 16'd0}),
        .i_den (r_c5.row_dist),
        .o_quo (quo_b)
    );

    fcts_div u_div_green (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem ('0),
        .i_low ({r_texel[15:8], 16'd0}),
        .i_den (r_c5.row_dist),
        .o_quo (quo_g)
    );

    fcts_div u_div_red (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem ('0),
        .i_low ({r_texel[23:16], 16'd0}),
        .i_den (r_c5.row_dist),
        .o_quo (quo_r)
    );

    logic r_vl3 [DIV_STAGES];
    t_ctx r_l3  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vl3[k] <= 1'b0;
            end
        end else if (en) begin
            r_vl3[0] <= r_v5;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_vl3[k] <= r_vl3[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l3[0] <= c_in3;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_l3[k] <= r_l3[k-1];
            end
        end
    end

    // output register: saturate colours, zero them for non-shaded results
    t_ctx       last;
    logic       shaded;
    logic [7:0] n_blue;
    logic [7:0] n_green;
    logic [7:0] n_red;
    logic [7:0] n_alpha;

    always_comb begin
        last    = r_l3[DIV_STAGES-1];
        shaded  = (last.status == ST_SHADED);
        n_blue  = (quo_b[Q_W-1:8] != '0) ? 8'hFF : quo_b[7:0];
        n_green = (quo_g[Q_W-1:8] != '0) ? 8'hFF : quo_g[7:0];
        n_red   = (quo_r[Q_W-1:8] != '0) ? 8'hFF : quo_r[7:0];
        n_alpha = last.texel[31:24];
        if (!shaded) begin
            n_blue  = '0;
            n_green = '0;
            n_red   = '0;
            n_alpha = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vl3[DIV_STAGES-1] && last.mode;
        end
    end

    logic [11:0] r_col;
    logic [9:0]  r_row;
    logic [7:0]  r_blue;
    logic [7:0]  r_green;
    logic [7:0]  r_red;
    logic [7:0]  r_alpha;
    logic [1:0]  r_status;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col    <= last.column;
            r_row    <= last.row;
            r_blue   <= n_blue;
            r_green  <= n_green;
            r_red    <= n_red;
            r_alpha  <= n_alpha;
            r_status <= last.status;
        end
    end

    assign o_valid        = r_vo;
    assign o_pixel_column = r_col;
    assign o_pixel_row    = r_row;
    assign o_blue         = r_blue;
    assign o_green        = r_green;
    assign o_red          = r_red;
    assign o_alpha        = r_alpha;
    assign o_status       = r_status;

endmodule
`default_nettype wire

// File: tb/tb_floor_cast_texel_shader_unit.sv
// ----------------------------------------------------------------------------
// tb_floor_cast_texel_shader_unit
// Self-checking bench for the floor texel shader. Each floor pixel that reads
// a texel not yet written is preceded by a write of that texel; directed and
// random floor pixels and texel writes are streamed through several register
// settings. A behavioural predictor works out each shaded pixel in order, and
// the monitor compares every result beat field by field while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_floor_cast_texel_shader_unit
    import fcts_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct {
        logic        mode;
        logic [11:0] column;
        logic [9:0]  row;
        logic        side;
        logic        rxp;
        logic        ryp;
        logic [7:0]  map_x;
        logic [7:0]  map_y;
        logic [15:0] fraction;
        logic [23:0] wall_dist;
        logic [12:0] address;
        logic [31:0] word;
    } t_beat;

    typedef struct {
        logic [11:0] column;
        logic [9:0]  row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        t_status     status;
    } t_pix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = 1'b0;
    logic [11:0] i_column = '0;
    logic [9:0]  i_row = '0;
    logic        i_side = 1'b0;
    logic        i_ray_x_positive = 1'b0;
    logic        i_ray_y_positive = 1'b0;
    logic [7:0]  i_map_x = '0;
    logic [7:0]  i_map_y = '0;
    logic [15:0] i_wall_fraction = '0;
    logic [23:0] i_wall_distance = '0;
    logic [12:0] i_load_address = '0;
    logic [31:0] i_load_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [11:0] o_pixel_column;
    logic [9:0]  o_pixel_row;
    logic [7:0]  o_blue;
    logic [7:0]  o_green;
    logic [7:0]  o_red;
    logic [7:0]  o_alpha;
    logic [1:0]  o_status;

    floor_cast_texel_shader_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_column         (i_column),
        .i_row            (i_row),
        .i_side           (i_side),
        .i_ray_x_positive (i_ray_x_positive),
        .i_ray_y_positive (i_ray_y_positive),
        .i_map_x          (i_map_x),
        .i_map_y          (i_map_y),
        .i_wall_fraction  (i_wall_fraction),
        .i_wall_distance  (i_wall_distance),
        .i_load_address   (i_load_address),
        .i_load_word      (i_load_word),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pixel_column   (o_pixel_column),
        .o_pixel_row      (o_pixel_row),
        .o_blue           (o_blue),
        .o_green          (o_green),
        .o_red            (o_red),
        .o_alpha          (o_alpha),
        .o_status         (o_status)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register mirror and texture store copy
    logic [9:0]  height_reg = 10'd480;
    logic [23:0] pos_x_reg  = '0;
    logic [23:0] pos_y_reg  = '0;
    logic [1:0]  choice_reg = 2'd1;
    logic [31:0] texel_mem [0:STORE_DEPTH-1];
    bit          gen_written [0:STORE_DEPTH-1];

    t_beat pending_beats[$];
    t_pix  pixel_due[$];
    t_beat cur_beat;
    int    mismatches = 0;
    bit    tight = 1'b0;
    bit    hold_req = 1'b0;
    int    send_gap = 0;
    int    stall_left = 0;
    int    quiet_cycles = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // texel coordinate of the interpolated floor point
    function automatic int floor_coord(longint wall_q, longint pos_q, longint w);
        longint s;
        s = w * wall_q + (64'sd65536 - w) * pos_q;
        return int'(((s * TEX_SIZE) >>> 32) & (TEX_SIZE - 1));
    endfunction

    function automatic logic [7:0] dim(logic [7:0] c, longint row_dist);
        longint v;
        v = (longint'(c) << 16) / row_dist;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // row distance under the current registers, saturated
    function automatic longint row_distance(logic [9:0] row);
        longint d;
        d = (longint'(height_reg) << 16) / (2 * longint'(row) - longint'(height_reg));
        if (d > 64'hFFFFFF) d = 64'hFFFFFF;
        return d;
    endfunction

    // store index read by a shade beat, or -1 when no texel is read
    function automatic int texel_index(t_beat b);
        longint row_dist, w, wd, wx, wy;
        int     tx, ty;
        if (2 * int'(b.row) <= int'(height_reg) || choice_reg == 2'd0 ||
            choice_reg == 2'd3 || int'(choice_reg) - 1 >= TEX_COUNT)
            return -1;
        row_dist = row_distance(b.row);
        wd = (b.wall_dist == 0) ? 1 : longint'(b.wall_dist);
        w = (row_dist << 16) / wd;
        if (w > 64'hFFFFFF) w = 64'hFFFFFF;
        if (!b.side) begin
            wx = (longint'(b.map_x) << 16) + (b.rxp ? 0 : 65536);
            wy = (longint'(b.map_y) << 16) + longint'(b.fraction);
        end else begin
            wx = (longint'(b.map_x) << 16) + longint'(b.fraction);
            wy = (longint'(b.map_y) << 16) + (b.ryp ? 0 : 65536);
        end
        tx = floor_coord(wx, longint'(pos_x_reg), w);
        ty = floor_coord(wy, longint'(pos_y_reg), w);
        return ((int'(choice_reg) - 1) * TEX_SIZE + ty) * TEX_SIZE + tx;
    endfunction

    // expected pixel for a shade beat under the current registers
    function automatic t_pix shade_pixel(t_beat b);
        t_pix   p;
        longint row_dist;
        logic [31:0] tex;
        p.column = b.column;
        p.row    = b.row;
        p.blue = '0; p.green = '0; p.red = '0; p.alpha = '0;
        p.status = ST_SHADED;
        if (2 * int'(b.row) <= int'(height_reg)) begin
            p.status = ST_HORIZON;
        end else if (choice_reg == 2'd0 || choice_reg == 2'd3 ||
                     int'(choice_reg) - 1 >= TEX_COUNT) begin
            p.status = ST_NO_TEXTURE;
        end else begin
            row_dist = row_distance(b.row);
            tex      = texel_mem[texel_index(b)];
            p.blue  = dim(tex[7:0], row_dist);
            p.green = dim(tex[15:8], row_dist);
            p.red   = dim(tex[23:16], row_dist);
            p.alpha = tex[31:24];
        end
        return p;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (cur_beat.mode)
                    pixel_due.push_back(shade_pixel(cur_beat));
                else if (int'(cur_beat.address) < STORE_DEPTH)
                    texel_mem[cur_beat.address] = cur_beat.word;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    i_mode           <= cur_beat.mode;
                    i_column         <= cur_beat.column;
                    i_row            <= cur_beat.row;
                    i_side           <= cur_beat.side;
                    i_ray_x_positive <= cur_beat.rxp;
                    i_ray_y_positive <= cur_beat.ryp;
                    i_map_x          <= cur_beat.map_x;
                    i_map_y          <= cur_beat.map_y;
                    i_wall_fraction  <= cur_beat.fraction;
                    i_wall_distance  <= cur_beat.wall_dist;
                    i_load_address   <= cur_beat.address;
                    i_load_word      <= cur_beat.word;
                    i_valid          <= 1'b1;
                    send_gap = tight ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge i_clk) begin
        t_pix p;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pixel_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat col=%0d row=%0d",
                                 o_pixel_column, o_pixel_row);
                end else begin
                    p = pixel_due.pop_front();
                    if (o_pixel_column !== p.column || o_pixel_row !== p.row ||
                        o_blue !== p.blue || o_green !== p.green || o_red !== p.red ||
                        o_alpha !== p.alpha || o_status !== p.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp col=%0d row=%0d b=%0d g=%0d r=%0d",
                                      " a=%0d st=%0d | got col=%0d row=%0d b=%0d g=%0d",
                                      " r=%0d a=%0d st=%0d"},
                                     p.column, p.row, p.blue, p.green, p.red, p.alpha,
                                     p.status, o_pixel_column, o_pixel_row, o_blue,
                                     o_green, o_red, o_alpha, o_status);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = tight ? 0 : pick_gap();
                i_stall <= (stall_left > 0);
            end
        end
    end

    // watchdog on cycles with work pending and no beat moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (pending_beats.size() == 0 && !i_valid && pixel_due.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_beat texel_write(logic [12:0] addr, logic [31:0] word);
        t_beat b;
        b.mode = 1'b0;
        b.column = 12'($urandom); b.row = 10'($urandom); b.side = 1'($urandom);
        b.rxp = 1'($urandom); b.ryp = 1'($urandom);
        b.map_x = 8'($urandom); b.map_y = 8'($urandom);
        b.fraction = 16'($urandom); b.wall_dist = 24'($urandom);
        b.address = addr;
        b.word = word;
        return b;
    endfunction

    // queue a texel write and note the texel as written
    function automatic void push_write(logic [12:0] addr, logic [31:0] word);
        if (int'(addr) < STORE_DEPTH)
            gen_written[addr] = 1'b1;
        pending_beats.push_back(texel_write(addr, word));
    endfunction

    // queue a floor pixel, writing its texel first when it is still unwritten
    function automatic void push_pixel(t_beat b);
        int idx;
        idx = texel_index(b);
        if (idx >= 0 && !gen_written[idx])
            push_write(13'(idx), ($urandom_range(0, 2) == 0) ? 32'hFFFFFFFF : $urandom);
        pending_beats.push_back(b);
    endfunction

    // random floor pixel, mostly below the horizon
    function automatic t_beat floor_pixel();
        t_beat b;
        b = texel_write(13'($urandom), $urandom);
        b.mode = 1'b1;
        if ($urandom_range(0, 99) < 85)
            b.row = 10'($urandom_range(int'(height_reg) / 2 + 1, 1023));
        case ($urandom_range(0, 3))
            0: b.wall_dist = 24'($urandom_range(1, 24'hFFFF));
            1: b.wall_dist = 24'($urandom_range(24'h10000, 24'h1FFFFF));
            default: b.wall_dist = 24'($urandom);
        endcase
        return b;
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() > 0 || i_valid || pixel_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [23:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SCREEN_HEIGHT: height_reg = data[9:0];
            REG_PLAYER_X:      pos_x_reg  = data;
            REG_PLAYER_Y:      pos_y_reg  = data;
            default:           choice_reg = data[1:0];
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_view(int h, int px, int py, int sel);
        wait_idle();
        write_reg(REG_SCREEN_HEIGHT, 24'(h));
        write_reg(REG_PLAYER_X, 24'(px));
        write_reg(REG_PLAYER_Y, 24'(py));
        write_reg(REG_TEXTURE_CHOICE, 24'(sel));
    endtask

    // stimulus
    initial begin
        t_beat b;
        int    i, ph, sel;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tight = 1'b1;
        set_view(480, 0, 0, 1);
        tight = 1'b0;

        // directed pixels at reset-like view
        b = floor_pixel(); b.row = 10'd0;   b.column = 12'd0;   push_pixel(b);
        b = floor_pixel(); b.row = 10'd240; b.column = 12'hFFF; push_pixel(b);
        b = floor_pixel(); b.row = 10'd241; b.wall_dist = 24'h1; push_pixel(b);
        b = floor_pixel(); b.row = 10'd1023; b.wall_dist = 24'hFFFFFF;
        push_pixel(b);
        b = floor_pixel(); b.wall_dist = 24'd0;                 push_pixel(b);
        for (i = 0; i < 4; i++) begin
            b = floor_pixel();
            b.side = i[0]; b.rxp = i[1]; b.ryp = ~i[1];
            b.map_x = i[0] ? 8'hFF : 8'h00; b.map_y = i[1] ? 8'hFF : 8'h00;
            b.fraction = i[0] ? 16'hFFFF : 16'h0;
            b.row = 10'(300 + i);
            push_pixel(b);
        end
        push_write(13'h1FFF, 32'h80FF7F01);
        push_write(13'h0000, 32'h00000000);

        // second texture, full player position, large height with row below H
        set_view(1023, 24'hFFFFFF, 24'hFFFFFF, 2);
        for (i = 0; i < 6; i++) begin
            b = floor_pixel(); b.row = 10'(512 + i * 100); push_pixel(b);
        end
        b = floor_pixel(); b.row = 10'd511; push_pixel(b);

        // no-texture selections and smallest height
        set_view(2, 24'h0, 24'h123456, 0);
        b = floor_pixel(); b.row = 10'd2; push_pixel(b);
        b = floor_pixel(); b.row = 10'd1; push_pixel(b);
        set_view(2, 24'h800000, 24'h0, 3);
        b = floor_pixel(); b.row = 10'd1023; push_pixel(b);
        b = floor_pixel(); b.row = 10'd1;    push_pixel(b);

        // random phases
        for (ph = 0; ph < 7; ph++) begin
            sel = (ph == 5) ? $urandom_range(0, 3) : $urandom_range(1, 2);
            set_view($urandom_range(2, 1023), $urandom, $urandom, sel);
            tight = (ph == 3);
            if (ph == 2) hold_req = 1'b1;
            for (i = 0; i < 30; i++) begin
                if ($urandom_range(0, 99) < 20)
                    push_write(13'($urandom), $urandom);
                else
                    push_pixel(floor_pixel());
            end
        end
        tight = 1'b0;

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: floor_cast_texel_shader_unit.f
design/fcts_pkg.sv
design/fcts_div.sv
design/floor_cast_texel_shader_unit.sv
tb/tb_floor_cast_texel_shader_unit.sv
